// ===== rtl/plfr_pkg.sv =====
// Shared types and constants for the pedal link frame receiver.
// No dependencies; imported by the receiver and its port checker.
package plfr_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int CHECK_BYTES = 6;
	localparam int IDLE_W = 17;
	localparam int TIMEOUT_W = 13;
	localparam int TICK_W = 10;
	localparam int FILL_W = $clog2(FRAME_BYTES);
	localparam int ADDR_W = 5;

	// Frame byte positions
	localparam logic [FILL_W-1:0] POS_HDR0 = FILL_W'(0);
	localparam logic [FILL_W-1:0] POS_HDR1 = FILL_W'(1);
	localparam int POS_SEQ = 2;
	localparam int POS_THR_LO = 3;
	localparam int POS_THR_HI = 4;
	localparam int POS_FLAGS = 5;
	localparam int POS_CHECK = 6;
	localparam logic [FILL_W-1:0] POS_TAIL = FILL_W'(FRAME_BYTES - 1);

	// Item kinds
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Frame event codes
	localparam logic [1:0] FE_NONE = 2'd0;
	localparam logic [1:0] FE_GOOD = 2'd1;
	localparam logic [1:0] FE_BAD = 2'd2;

	// Register indexes (byte address 4*index)
	localparam logic [2:0] REG_HDR0 = 3'd0;
	localparam logic [2:0] REG_HDR1 = 3'd1;
	localparam logic [2:0] REG_TAIL = 3'd2;
	localparam logic [2:0] REG_THR_LIMIT = 3'd3;
	localparam logic [2:0] REG_BRAKE_MASK = 3'd4;
	localparam logic [2:0] REG_TIMEOUT = 3'd5;

	// Register reset values
	localparam logic [7:0] RST_HDR0 = 8'd170;
	localparam logic [7:0] RST_HDR1 = 8'd85;
	localparam logic [7:0] RST_TAIL = 8'd13;
	localparam logic [15:0] RST_THR_LIMIT = 16'd1000;
	localparam logic [7:0] RST_BRAKE_MASK = 8'd1;
	localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = TIMEOUT_W'(100);

	typedef struct packed {
		logic func;
		logic [7:0] rx_byte;
		logic [TICK_W-1:0] tick_ms;
	} item_t;

	typedef struct packed {
		logic link_online;
		logic [15:0] throttle_pm;
		logic brake_on;
		logic [7:0] flag_bits;
		logic [1:0] frame_event;
		logic [7:0] seq_gap;
		logic [31:0] good_frames;
		logic [31:0] bad_frames;
		logic [31:0] missed_frames;
		logic [31:0] link_losses;
		logic [31:0] bytes_seen;
	} result_t;

endpackage

// ===== rtl/pedal_link_frame_receiver.sv =====
// Pedal link frame receiver: deframer, frame check, link watchdog and statistics.
// Depends on plfr_pkg for the item/result structs, codes and register map.

// One item (received byte or time tick) is taken per clock cycle while item_ready is
// high, and its result appears in the result register in the next cycle. All work for
// an item is done in one pass of logic between the item port and that register, so
// item_ready drops only while a result waits and the consumer holds result_ready low.
// Frames are 8 bytes: two header bytes, sequence, throttle low/high, flags,
// XOR check and trailer. Registers sit at byte addresses 0x00..0x14 (header 0,
// header 1, trailer, throttle limit, brake flag mask, loss timeout in ms) and
// should be written only while no item is in flight.
module pedal_link_frame_receiver
	import plfr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input item_t item,
	output logic result_valid,
	input logic result_ready,
	output result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	// Configuration registers
	logic [7:0] hdr0_q, hdr1_q, tail_q, brake_mask_q;
	logic [15:0] thr_limit_q;
	logic [TIMEOUT_W-1:0] timeout_q;

	// Link and frame state
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [7:0] frame_q [0:FRAME_BYTES-2];
	logic [7:0] prev_seq_q, prev_seq_d;
	logic seq_known_q, seq_known_d;
	logic [IDLE_W-1:0] idle_q, idle_d;
	logic online_q, online_d;
	logic [15:0] throttle_q, throttle_d;
	logic brake_q, brake_d;
	logic [7:0] flags_q, flags_d;
	logic [31:0] good_q, good_d, bad_q, bad_d, missed_q, missed_d;
	logic [31:0] losses_q, losses_d, bytes_q, bytes_d;

	logic store_en;
	logic [FILL_W-1:0] store_idx;
	logic [7:0] store_byte;

	logic item_fire;
	logic [1:0] event_d;
	logic [7:0] gap_d;
	logic [7:0] xor_sum;
	logic [15:0] rx_throttle;
	logic [IDLE_W-1:0] idle_cap;
	logic [IDLE_W:0] idle_sum;
	logic now_online;
	logic cfg_write;
	logic [2:0] reg_idx;

	result_t result_q;
	logic result_valid_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_q <= RST_HDR0;
			hdr1_q <= RST_HDR1;
			tail_q <= RST_TAIL;
			thr_limit_q <= RST_THR_LIMIT;
			brake_mask_q <= RST_BRAKE_MASK;
			timeout_q <= RST_TIMEOUT;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_HDR0: hdr0_q <= pwdata[7:0];
				REG_HDR1: hdr1_q <= pwdata[7:0];
				REG_TAIL: tail_q <= pwdata[7:0];
				REG_THR_LIMIT: thr_limit_q <= pwdata[15:0];
				REG_BRAKE_MASK: brake_mask_q <= pwdata[7:0];
				REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HDR0: prdata = {24'd0, hdr0_q};
			REG_HDR1: prdata = {24'd0, hdr1_q};
			REG_TAIL: prdata = {24'd0, tail_q};
			REG_THR_LIMIT: prdata = {16'd0, thr_limit_q};
			REG_BRAKE_MASK: prdata = {24'd0, brake_mask_q};
			REG_TIMEOUT: prdata = {{(32-TIMEOUT_W){1'b0}}, timeout_q};
			default: prdata = 32'd0;
		endcase
	end

	assign item_ready = !result_valid_q || result_ready;
	assign item_fire = item_valid && item_ready;

	// Check over the stored bytes; the tail arrives as the current byte
	always_comb begin
		xor_sum = 8'd0;
		for (int i = 0; i < CHECK_BYTES; i++) begin
			xor_sum = xor_sum ^ frame_q[i];
		end
	end

	assign rx_throttle = {frame_q[POS_THR_HI], frame_q[POS_THR_LO]};
	// Idle cap is ten times the timeout: 8x + 2x
	assign idle_cap = IDLE_W'({timeout_q, 3'b000}) + IDLE_W'({timeout_q, 1'b0});
	assign idle_sum = {1'b0, idle_q} + (IDLE_W+1)'(item.tick_ms);

	always_comb begin
		fill_d = fill_q;
		prev_seq_d = prev_seq_q;
		seq_known_d = seq_known_q;
		idle_d = idle_q;
		online_d = online_q;
		throttle_d = throttle_q;
		brake_d = brake_q;
		flags_d = flags_q;
		good_d = good_q;
		bad_d = bad_q;
		missed_d = missed_q;
		losses_d = losses_q;
		bytes_d = bytes_q;
		store_en = 1'b0;
		store_idx = fill_q;
		store_byte = item.rx_byte;
		event_d = FE_NONE;
		gap_d = 8'd0;
		now_online = 1'b0;

		if (item_fire && item.func == FUNC_BYTE) begin
			bytes_d = bytes_q + 32'd1;
			priority if (fill_q == POS_HDR0) begin
				if (item.rx_byte == hdr0_q) begin
					store_en = 1'b1;
					fill_d = fill_q + FILL_W'(1);
				end
			end else if (fill_q == POS_HDR1 && item.rx_byte != hdr1_q) begin
				// resync: a fresh first header byte restarts the frame at once
				store_en = 1'b1;
				store_idx = POS_HDR0;
				store_byte = hdr0_q;
				fill_d = (item.rx_byte == hdr0_q) ? POS_HDR1 : POS_HDR0;
			end else if (fill_q != POS_TAIL) begin
				store_en = 1'b1;
				fill_d = fill_q + FILL_W'(1);
			end else begin
				fill_d = POS_HDR0;
				if (item.rx_byte != tail_q || xor_sum != frame_q[POS_CHECK]) begin
					bad_d = bad_q + 32'd1;
					event_d = FE_BAD;
				end else begin
					good_d = good_q + 32'd1;
					event_d = FE_GOOD;
					if (seq_known_q) begin
						gap_d = frame_q[POS_SEQ] - prev_seq_q - 8'd1;
						missed_d = missed_q + 32'(gap_d);
					end
					prev_seq_d = frame_q[POS_SEQ];
					seq_known_d = 1'b1;
					throttle_d = (rx_throttle > thr_limit_q) ? thr_limit_q : rx_throttle;
					flags_d = frame_q[POS_FLAGS];
					brake_d = |(frame_q[POS_FLAGS] & brake_mask_q);
					idle_d = '0;
				end
			end
		end else if (item_fire) begin
			idle_d = (idle_sum > {1'b0, idle_cap}) ? idle_cap : idle_sum[IDLE_W-1:0];
			now_online = (idle_d <= IDLE_W'(timeout_q));
			if (online_q && !now_online) begin
				losses_d = losses_q + 32'd1;
				throttle_d = 16'd0;
				brake_d = 1'b1;
				seq_known_d = 1'b0;
			end
			online_d = now_online;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= POS_HDR0;
			prev_seq_q <= 8'd0;
			seq_known_q <= 1'b0;
			idle_q <= '1;
			online_q <= 1'b0;
			throttle_q <= 16'd0;
			brake_q <= 1'b1;
			flags_q <= 8'd0;
			good_q <= 32'd0;
			bad_q <= 32'd0;
			missed_q <= 32'd0;
			losses_q <= 32'd0;
			bytes_q <= 32'd0;
		end else begin
			fill_q <= fill_d;
			prev_seq_q <= prev_seq_d;
			seq_known_q <= seq_known_d;
			idle_q <= idle_d;
			online_q <= online_d;
			throttle_q <= throttle_d;
			brake_q <= brake_d;
			flags_q <= flags_d;
			good_q <= good_d;
			bad_q <= bad_d;
			missed_q <= missed_d;
			losses_q <= losses_d;
			bytes_q <= bytes_d;
		end
	end

	always_ff @(posedge clk) begin
		if (store_en && store_idx != POS_TAIL) begin
			frame_q[store_idx] <= store_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_ready) begin
			result_valid_q <= item_valid;
		end
	end

	// Hold the result while the consumer stalls
	always_ff @(posedge clk) begin
		if (item_fire) begin
			result_q.link_online <= online_d;
			result_q.throttle_pm <= throttle_d;
			result_q.brake_on <= brake_d;
			result_q.flag_bits <= flags_d;
			result_q.frame_event <= event_d;
			result_q.seq_gap <= gap_d;
			result_q.good_frames <= good_d;
			result_q.bad_frames <= bad_d;
			result_q.missed_frames <= missed_d;
			result_q.link_losses <= losses_d;
			result_q.bytes_seen <= bytes_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== rtl/plfr_checker.sv =====
// Port-level checks for the pedal link frame receiver, bound to the top level.
// Depends on plfr_pkg for the structs and frame event codes.
module plfr_checker
	import plfr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input item_t item,
	input logic result_valid,
	input logic result_ready,
	input result_t result
);

	// A stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// The result register never blocks input while it is free
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item_ready low with empty result register");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.frame_event == FE_NONE || result.frame_event == FE_GOOD
			|| result.frame_event == FE_BAD))
		else $error("bad frame event code");

	// A gap is reported only with an accepted frame
	a_gap_only_good: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.seq_gap != 8'd0 |-> result.frame_event == FE_GOOD)
		else $error("sequence gap without accepted frame");

	// Every accepted item beat leaves a result beat in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("no result beat after accepted item");

endmodule

bind pedal_link_frame_receiver plfr_checker u_plfr_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for pedal_link_frame_receiver: directed rows, then random frame traffic.
// Needs plfr_pkg and the receiver RTL; predicts every result beat in a model of its own.

module tb;
	import plfr_pkg::*;

	localparam int N_SETTINGS = 6;
	localparam int TRAFFIC_ITEMS = 120;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int UNMAPPED_A = 6;
	localparam int UNMAPPED_B = 7;
	localparam int N_REGS = 6;
	localparam logic [31:0] REG_MASKS [N_REGS] = '{32'hFF, 32'hFF, 32'hFF, 32'hFFFF, 32'hFF,
		32'h1FFF};

	typedef enum int {FAULT_NONE, FAULT_CHECK, FAULT_TAIL, FAULT_HDR1, FAULT_SHORT} frame_fault_t;
	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BLOCK} sink_mode_t;

	typedef struct {
		item_t it;
		bit pin;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// sideband that travels with the item: a hand-typed expectation replaces the prediction
	logic item_pin = 1'b0;
	result_t item_pin_res = '0;

	pedal_link_frame_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register copy and receiver state as the bench sees them
	logic [31:0] cfg_regs [N_REGS] = '{32'(RST_HDR0), 32'(RST_HDR1), 32'(RST_TAIL),
		32'(RST_THR_LIMIT), 32'(RST_BRAKE_MASK), 32'(RST_TIMEOUT)};
	int m_fill = 0;
	logic [7:0] m_store [FRAME_BYTES];
	logic [7:0] m_prev_seq = '0;
	logic m_seq_known = 1'b0;
	logic [IDLE_W-1:0] m_idle = '1;
	logic m_online = 1'b0;
	logic [15:0] m_throttle = '0;
	logic m_brake = 1'b1;
	logic [7:0] m_flags = '0;
	logic [31:0] m_good = '0;
	logic [31:0] m_bad = '0;
	logic [31:0] m_missed = '0;
	logic [31:0] m_losses = '0;
	logic [31:0] m_bytes = '0;

	result_t results_due [$];
	int mismatches = 0;
	int items_sent = 0;
	int stall_cycles = 0;
	int burst_left = 0;
	logic [7:0] next_seq = '0;

	function automatic result_t predict_link_result(item_t it);
		result_t r;
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] gap;
		logic [1:0] ev;
		logic [15:0] thr;
		int unsigned cap;
		int unsigned span;
		logic now_up;
		b = it.rx_byte;
		ev = FE_NONE;
		gap = '0;
		if (it.func == FUNC_BYTE) begin
			m_bytes++;
			if (m_fill == 1 && b != cfg_regs[REG_HDR1][7:0]) begin
				// resync: a repeated first header byte keeps the frame open
				m_fill = (b == cfg_regs[REG_HDR0][7:0]) ? 1 : 0;
				m_store[0] = cfg_regs[REG_HDR0][7:0];
			end else if (m_fill != 0 || b == cfg_regs[REG_HDR0][7:0]) begin
				m_store[m_fill] = b;
				m_fill++;
				if (m_fill == FRAME_BYTES) begin
					m_fill = 0;
					sum = '0;
					for (int i = 0; i < CHECK_BYTES; i++)
						sum ^= m_store[i];
					if (m_store[POS_TAIL] != cfg_regs[REG_TAIL][7:0] ||
						sum != m_store[POS_CHECK]) begin
						m_bad++;
						ev = FE_BAD;
					end else begin
						m_good++;
						ev = FE_GOOD;
						if (m_seq_known) begin
							gap = m_store[POS_SEQ] - m_prev_seq - 8'd1;
							m_missed += 32'(gap);
						end
						m_prev_seq = m_store[POS_SEQ];
						m_seq_known = 1'b1;
						thr = {m_store[POS_THR_HI], m_store[POS_THR_LO]};
						m_throttle = (thr > cfg_regs[REG_THR_LIMIT][15:0]) ?
							cfg_regs[REG_THR_LIMIT][15:0] : thr;
						m_flags = m_store[POS_FLAGS];
						m_brake = |(m_flags & cfg_regs[REG_BRAKE_MASK][7:0]);
						m_idle = '0;
					end
				end
			end
		end else begin
			cap = cfg_regs[REG_TIMEOUT] * 32'd10;
			span = 32'(m_idle) + 32'(it.tick_ms);
			if (span > cap)
				span = cap;
			m_idle = span[IDLE_W-1:0];
			now_up = (32'(m_idle) <= cfg_regs[REG_TIMEOUT]);
			if (m_online && !now_up) begin
				m_losses++;
				m_throttle = '0;
				m_brake = 1'b1;
				m_seq_known = 1'b0;
			end
			m_online = now_up;
		end
		r.link_online = m_online;
		r.throttle_pm = m_throttle;
		r.brake_on = m_brake;
		r.flag_bits = m_flags;
		r.frame_event = ev;
		r.seq_gap = gap;
		r.good_frames = m_good;
		r.bad_frames = m_bad;
		r.missed_frames = m_missed;
		r.link_losses = m_losses;
		r.bytes_seen = m_bytes;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Scoreboard: compare each result beat with the oldest prediction, then predict new beats
	always @(posedge clk) begin : scoreboard
		result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %h", $time, result);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("link_online", 32'(want.link_online), 32'(result.link_online));
					check_field("throttle_pm", 32'(want.throttle_pm), 32'(result.throttle_pm));
					check_field("brake_on", 32'(want.brake_on), 32'(result.brake_on));
					check_field("flag_bits", 32'(want.flag_bits), 32'(result.flag_bits));
					check_field("frame_event", 32'(want.frame_event), 32'(result.frame_event));
					check_field("seq_gap", 32'(want.seq_gap), 32'(result.seq_gap));
					check_field("good_frames", want.good_frames, result.good_frames);
					check_field("bad_frames", want.bad_frames, result.bad_frames);
					check_field("missed_frames", want.missed_frames, result.missed_frames);
					check_field("link_losses", want.link_losses, result.link_losses);
					check_field("bytes_seen", want.bytes_seen, result.bytes_seen);
				end
			end
			if (item_valid && item_ready) begin
				want = predict_link_result(item);
				results_due.push_back(item_pin ? item_pin_res : want);
			end
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Result sink: switch at random between open, coin-flip, sparse and blocking stall patterns
	sink_mode_t sink_mode = SINK_OPEN;
	int sink_timer = 0;
	int sink_phase = 0;
	always @(posedge clk) begin
		if (sink_timer == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
			sink_timer <= $urandom_range(20, 80);
		end else begin
			sink_timer <= sink_timer - 1;
		end
		sink_phase <= sink_phase + 1;
		case (sink_mode)
			SINK_OPEN: result_ready <= 1'b1;
			SINK_COIN: result_ready <= 1'($urandom_range(0, 1));
			SINK_SPARSE: result_ready <= (sink_phase % 4 == 0);
			default: result_ready <= (sink_phase % 16 == 15);
		endcase
	end

	// Drive one item; returns at the edge where it is accepted
	task automatic send_item(input item_t it, input bit pin = 1'b0, input result_t want = '0);
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		item <= it;
		item_pin <= pin;
		item_pin_res <= want;
		item_valid <= 1'b1;
		burst_left--;
		items_sent++;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_byte(input logic [7:0] b);
		item_t it;
		it.func = FUNC_BYTE;
		it.rx_byte = b;
		it.tick_ms = TICK_W'($urandom);
		send_item(it);
	endtask

	task automatic send_tick();
		item_t it;
		int pick;
		int span;
		pick = $urandom_range(0, 9);
		span = cfg_regs[REG_TIMEOUT] / 3;
		if (span > 1023)
			span = 1023;
		it.func = FUNC_TICK;
		it.rx_byte = 8'($urandom);
		if (pick < 7)
			it.tick_ms = TICK_W'($urandom_range(0, span));
		else if (pick < 9)
			it.tick_ms = TICK_W'($urandom_range(0, 1023));
		else
			it.tick_ms = '1;
		send_item(it);
	endtask

	task automatic send_frame(input frame_fault_t fault);
		logic [7:0] fb [FRAME_BYTES];
		logic [15:0] thr;
		logic [15:0] lim;
		int last;
		lim = cfg_regs[REG_THR_LIMIT][15:0];
		thr = ($urandom_range(0, 3) == 0) ? lim + 16'($urandom_range(0, 4)) - 16'd2 :
			16'($urandom);
		fb[POS_HDR0] = cfg_regs[REG_HDR0][7:0];
		fb[POS_HDR1] = cfg_regs[REG_HDR1][7:0];
		fb[POS_SEQ] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : next_seq;
		next_seq = fb[POS_SEQ] + 8'd1;
		fb[POS_THR_LO] = thr[7:0];
		fb[POS_THR_HI] = thr[15:8];
		fb[POS_FLAGS] = 8'($urandom);
		fb[POS_CHECK] = '0;
		for (int i = 0; i < CHECK_BYTES; i++)
			fb[POS_CHECK] ^= fb[i];
		fb[POS_TAIL] = cfg_regs[REG_TAIL][7:0];
		last = FRAME_BYTES - 1;
		case (fault)
			FAULT_CHECK: fb[POS_CHECK] ^= 8'($urandom_range(1, 255));
			FAULT_TAIL: fb[POS_TAIL] ^= 8'($urandom_range(1, 255));
			FAULT_HDR1: fb[POS_HDR1] ^= 8'($urandom_range(1, 255));
			FAULT_SHORT: last = $urandom_range(2, 6);
			default: ;
		endcase
		for (int i = 0; i <= last; i++)
			send_byte(fb[i]);
	endtask

	task automatic run_traffic(input int count);
		int stop_at;
		int pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_frame(FAULT_NONE);
			end else if (pick < 65) begin
				send_frame(frame_fault_t'($urandom_range(1, 4)));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4))
					send_byte(($urandom_range(0, 3) == 0) ? cfg_regs[REG_HDR0][7:0] :
						8'($urandom));
			end else begin
				send_tick();
			end
		end
	endtask

	task automatic write_reg(input int idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx < N_REGS)
			cfg_regs[idx] = value & REG_MASKS[idx];
	endtask

	task automatic read_reg(input int idx);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		do @(posedge clk); while (!pready);
		check_field("prdata", cfg_regs[idx], got);
	endtask

	// Wait until every predicted beat has come back, then let the block settle
	task automatic drain();
		do @(posedge clk); while (results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_setting(input int setting);
		logic [31:0] val [N_REGS];
		case (setting)
			1: val = '{32'h00, 32'h00, 32'h00, 32'h0000, 32'h00, 32'd1};
			2: val = '{32'hFF, 32'hFF, 32'hFF, 32'hFFFF, 32'hFF, 32'd6000};
			default: begin
				val[REG_HDR0] = $urandom_range(0, 255);
				val[REG_HDR1] = $urandom_range(0, 255);
				val[REG_TAIL] = $urandom_range(0, 255);
				val[REG_THR_LIMIT] = $urandom_range(0, 65535);
				val[REG_BRAKE_MASK] = $urandom_range(0, 255);
				val[REG_TIMEOUT] = (setting == 3) ? 0 : $urandom_range(1, 6000);
			end
		endcase
		// junk in the unused upper bits must be dropped
		for (int r = 0; r < N_REGS; r++)
			write_reg(r, ($urandom & ~REG_MASKS[r]) | val[r]);
		write_reg(UNMAPPED_A, $urandom);
		write_reg(UNMAPPED_B, $urandom);
		for (int r = 0; r < N_REGS; r++)
			read_reg(r);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Directed rows under reset settings; typed rows carry their expected beat
	dir_row_t directed_rows [29] = '{
		'{'{FUNC_TICK, 8'h00, 10'd0}, 1'b1,
			'{1'b0, 16'd0, 1'b1, 8'h00, FE_NONE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{'{FUNC_TICK, 8'hFF, 10'd1023}, 1'b1,
			'{1'b0, 16'd0, 1'b1, 8'h00, FE_NONE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{'{FUNC_BYTE, 8'hAA, 10'd0}, 1'b1,
			'{1'b0, 16'd0, 1'b1, 8'h00, FE_NONE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1}},
		'{'{FUNC_BYTE, 8'hAA, 10'd0}, 1'b1,
			'{1'b0, 16'd0, 1'b1, 8'h00, FE_NONE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd2}},
		'{'{FUNC_BYTE, 8'h55, 10'd0}, 1'b1,
			'{1'b0, 16'd0, 1'b1, 8'h00, FE_NONE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd3}},
		'{'{FUNC_BYTE, 8'h10, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'hFF, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'hFF, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h01, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'hEE, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h0D, 10'd0}, 1'b1,
			'{1'b0, 16'd1000, 1'b1, 8'h01, FE_GOOD, 8'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd9}},
		'{'{FUNC_TICK, 8'h00, 10'd5}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'hAA, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h55, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h13, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h00, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h00, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'hFE, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h12, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h0D, 10'd0}, 1'b1,
			'{1'b1, 16'd0, 1'b0, 8'hFE, FE_GOOD, 8'd2, 32'd2, 32'd0, 32'd2, 32'd0, 32'd17}},
		'{'{FUNC_TICK, 8'h00, 10'd1000}, 1'b1,
			'{1'b0, 16'd0, 1'b1, 8'hFE, FE_NONE, 8'd0, 32'd2, 32'd0, 32'd2, 32'd1, 32'd17}},
		'{'{FUNC_BYTE, 8'hAA, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h55, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h20, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h34, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h12, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'h00, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'hF9, 10'd0}, 1'b0, '0},
		'{'{FUNC_BYTE, 8'hFF, 10'd0}, 1'b1,
			'{1'b0, 16'd0, 1'b1, 8'hFE, FE_BAD, 8'd0, 32'd2, 32'd1, 32'd2, 32'd1, 32'd25}}
	};

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i].it, directed_rows[i].pin, directed_rows[i].want);
		for (int s = 0; s < N_SETTINGS; s++) begin
			if (s != 0) begin
				item_valid <= 1'b0;
				drain();
				load_setting(s);
			end
			run_traffic(TRAFFIC_ITEMS);
		end
		item_valid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d items across %0d register settings", items_sent, N_SETTINGS);
		$display("Frames good %0d, bad %0d, missed %0d, link losses %0d",
			m_good, m_bad, m_missed, m_losses);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

endmodule
